/* sv/dwm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwm_pkg
// shared widths, register indexes and reset values for densest_window_mean
// ----------------------------------------------------------------------------
package dwm_pkg;

    localparam int DEF_MAX_SAMPLES = 64;

    localparam int DATA_W  = 24;
    localparam int VAR_W   = 22;
    localparam int MINC_W  = 7;
    localparam int SIZE_W  = 7;
    localparam int CFG_W   = 22;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_VARIATION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT = 1'b1;

    localparam logic [VAR_W-1:0]  VARIATION_RST = 22'd256;
    localparam logic [MINC_W-1:0] MIN_COUNT_RST = 7'd1;

    typedef logic signed [DATA_W-1:0] t_sample;

endpackage

/* sv/densest_window_mean.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// densest_window_mean
// collects a burst of Q15.8 samples in sorted order and, on the marked word,
// reports the mean of the longest run whose span is within twice variation
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+------------------------------
//   in      | input     | i_in_valid / o_in_stall  | i_sample, i_last
//   out     | output    | o_out_valid / i_out_stall| o_mean, o_valid_res,
//           |           |                          | o_cluster_size, o_overflow
//   cfg     | input     | i_cfg_we                 | i_cfg_idx, i_cfg_data
//
// a word is sorted into the store as it arrives, moving each larger entry up one place
// on the marked word a two-pointer run search runs over the sorted store, then the
// run sum and a restoring divide of that sum by the run length
// all steps share one memory read port
// reset is synchronous; no clearing pass, the store is read only below count
// a stalled result holds in the output register while new words are taken
// ----------------------------------------------------------------------------
module densest_window_mean
    import dwm_pkg::*;
#(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [DATA_W-1:0]    i_sample,
    input  logic                 i_last,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [DATA_W-1:0]    o_mean,
    output logic                 o_valid_res,
    output logic [SIZE_W-1:0]    o_cluster_size,
    output logic                 o_overflow,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int CW   = $clog2(MAX_SAMPLES + 1);
    localparam int AW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int SW   = DATA_W + CW;
    localparam int DW   = $clog2(SW + 1);
    localparam int CMPW = (CW > MINC_W) ? CW : MINC_W;
    localparam int EW   = DATA_W + 2;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_INS     = 4'd1;
    localparam logic [3:0] ST_INS_W   = 4'd2;
    localparam logic [3:0] ST_SRCH_I  = 4'd3;
    localparam logic [3:0] ST_SRCH_IW = 4'd4;
    localparam logic [3:0] ST_SRCH_J  = 4'd5;
    localparam logic [3:0] ST_SRCH_JW = 4'd6;
    localparam logic [3:0] ST_EVAL    = 4'd7;
    localparam logic [3:0] ST_SUM     = 4'd8;
    localparam logic [3:0] ST_SUM_W   = 4'd9;
    localparam logic [3:0] ST_DIV_INI = 4'd10;
    localparam logic [3:0] ST_DIV     = 4'd11;
    localparam logic [3:0] ST_OUT     = 4'd12;

    logic [3:0]         r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic               r_dropped, n_dropped;
    logic               r_last, n_last;
    t_sample            r_v, n_v;
    logic [CW-1:0]      r_k, n_k;
    logic [CW-1:0]      r_i, n_i;
    logic [CW-1:0]      r_j, n_j;
    logic [CW-1:0]      r_best, n_best;
    logic [CW-1:0]      r_left, n_left;
    logic [CW-1:0]      r_idx, n_idx;
    t_sample            r_si, n_si;
    logic signed [SW-1:0] r_sum, n_sum;
    logic [CW-1:0]      r_rem, n_rem;
    logic [SW-1:0]      r_quo, n_quo;
    logic [DW-1:0]      r_divcnt, n_divcnt;
    logic               r_neg, n_neg;
    logic [VAR_W-1:0]   r_variation;
    logic [MINC_W-1:0]  r_min_count;
    logic               r_out_valid, n_out_valid;
    logic [DATA_W-1:0]  r_mean, n_mean;
    logic               r_valid_res, n_valid_res;
    logic [SIZE_W-1:0]  r_cluster_size, n_cluster_size;
    logic               r_overflow, n_overflow;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [DATA_W-1:0]  ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [DATA_W-1:0]  ram_rdata;

    logic               w_in_acc;
    logic [CW-1:0]      w_km1;
    logic [CW-1:0]      w_half;
    logic [CW-1:0]      w_len;
    logic               w_take;
    logic [CW-1:0]      w_best_sel;
    logic [CW-1:0]      w_left_sel;
    logic signed [EW-1:0] w_reach;
    logic signed [EW-1:0] w_rd_ext;
    logic [CW:0]        w_trial;
    logic               w_ge;
    logic [SW-1:0]      w_mag;
    logic [SW-1:0]      w_signed_q;
    logic [CMPW-1:0]    w_best_ext;
    logic               w_valid;

    dwm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    assign w_km1  = r_k - 1'b1;
    assign w_half = r_count >> 1;
    assign w_len  = r_j - r_i;
    assign w_take = (w_len >= r_best);
    assign w_best_sel = w_take ? w_len : r_best;
    assign w_left_sel = w_take ? r_i : r_left;

    // s[i] + 2 * variation, and the fetched s[j], both sign extended
    assign w_reach  = $signed({{2{r_si[DATA_W-1]}}, r_si})
                    + $signed({3'b000, r_variation, 1'b0});
    assign w_rd_ext = $signed({{2{ram_rdata[DATA_W-1]}}, ram_rdata});

    // one restoring divide step
    assign w_trial = {r_rem, r_quo[SW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_best});

    assign w_mag      = r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);
    assign w_signed_q = r_neg ? (~r_quo + 1'b1) : r_quo;
    assign w_best_ext = CMPW'(r_best);
    assign w_valid    = (w_best_ext >= CMPW'(r_min_count));

    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_dropped      = r_dropped;
        n_last         = r_last;
        n_v            = r_v;
        n_k            = r_k;
        n_i            = r_i;
        n_j            = r_j;
        n_best         = r_best;
        n_left         = r_left;
        n_idx          = r_idx;
        n_si           = r_si;
        n_sum          = r_sum;
        n_rem          = r_rem;
        n_quo          = r_quo;
        n_divcnt       = r_divcnt;
        n_neg          = r_neg;
        n_out_valid    = r_out_valid;
        n_mean         = r_mean;
        n_valid_res    = r_valid_res;
        n_cluster_size = r_cluster_size;
        n_overflow     = r_overflow;
        ram_we         = 1'b0;
        ram_waddr      = r_k[AW-1:0];
        ram_wdata      = r_v;
        ram_raddr      = r_i[AW-1:0];

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_last = i_last;
                    if (r_count < CW'(MAX_SAMPLES)) begin
                        n_v     = i_sample;
                        n_k     = r_count;
                        n_state = ST_INS;
                    end else begin
                        n_dropped = 1'b1;
                        if (i_last) begin
                            n_i     = '0;
                            n_j     = CW'(1);
                            n_best  = '0;
                            n_left  = '0;
                            n_state = ST_SRCH_I;
                        end
                    end
                end
            end
            ST_INS: begin
                if (r_k == '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = '0;
                    ram_wdata = r_v;
                    n_count   = r_count + 1'b1;
                    n_i       = '0;
                    n_j       = CW'(1);
                    n_best    = '0;
                    n_left    = '0;
                    n_state   = r_last ? ST_SRCH_I : ST_IDLE;
                end else begin
                    ram_raddr = w_km1[AW-1:0];
                    n_state   = ST_INS_W;
                end
            end
            ST_INS_W: begin
                ram_we    = 1'b1;
                ram_waddr = r_k[AW-1:0];
                if ($signed(ram_rdata) > r_v) begin
                    ram_wdata = ram_rdata;
                    n_k       = w_km1;
                    n_state   = ST_INS;
                end else begin
                    ram_wdata = r_v;
                    n_count   = r_count + 1'b1;
                    n_i       = '0;
                    n_j       = CW'(1);
                    n_best    = '0;
                    n_left    = '0;
                    n_state   = r_last ? ST_SRCH_I : ST_IDLE;
                end
            end
            ST_SRCH_I: begin
                ram_raddr = r_i[AW-1:0];
                n_state   = ST_SRCH_IW;
            end
            ST_SRCH_IW: begin
                n_si    = ram_rdata;
                n_state = ST_SRCH_J;
            end
            ST_SRCH_J: begin
                ram_raddr = r_j[AW-1:0];
                n_state   = (r_j < r_count) ? ST_SRCH_JW : ST_EVAL;
            end
            ST_SRCH_JW: begin
                if (w_rd_ext <= w_reach) begin
                    n_j     = r_j + 1'b1;
                    n_state = ST_SRCH_J;
                end else begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_best = w_best_sel;
                n_left = w_left_sel;
                if (r_i == w_half) begin
                    n_k     = w_left_sel;
                    n_idx   = w_best_sel;
                    n_sum   = '0;
                    n_state = ST_SUM;
                end else begin
                    n_i = r_i + 1'b1;
                    if (r_j == r_i + 1'b1) begin
                        n_j = r_i + CW'(2);
                    end
                    n_state = ST_SRCH_I;
                end
            end
            ST_SUM: begin
                ram_raddr = r_k[AW-1:0];
                n_state   = ST_SUM_W;
            end
            ST_SUM_W: begin
                n_sum   = r_sum + SW'($signed(ram_rdata));
                n_k     = r_k + 1'b1;
                n_idx   = r_idx - 1'b1;
                n_state = (r_idx == CW'(1)) ? ST_DIV_INI : ST_SUM;
            end
            ST_DIV_INI: begin
                n_neg    = r_sum[SW-1];
                n_quo    = w_mag;
                n_rem    = '0;
                n_divcnt = DW'(SW);
                n_state  = ST_DIV;
            end
            ST_DIV: begin
                n_rem    = w_ge ? CW'(w_trial - {1'b0, r_best}) : w_trial[CW-1:0];
                n_quo    = {r_quo[SW-2:0], w_ge};
                n_divcnt = r_divcnt - 1'b1;
                if (r_divcnt == DW'(1)) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid    = 1'b1;
                    n_mean         = w_valid ? w_signed_q[DATA_W-1:0] : '0;
                    n_valid_res    = w_valid;
                    n_cluster_size = w_best_ext[SIZE_W-1:0];
                    n_overflow     = r_dropped;
                    n_count        = '0;
                    n_dropped      = 1'b0;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last         <= n_last;
        r_v            <= n_v;
        r_k            <= n_k;
        r_i            <= n_i;
        r_j            <= n_j;
        r_best         <= n_best;
        r_left         <= n_left;
        r_idx          <= n_idx;
        r_si           <= n_si;
        r_sum          <= n_sum;
        r_rem          <= n_rem;
        r_quo          <= n_quo;
        r_divcnt       <= n_divcnt;
        r_neg          <= n_neg;
        r_mean         <= n_mean;
        r_valid_res    <= n_valid_res;
        r_cluster_size <= n_cluster_size;
        r_overflow     <= n_overflow;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_variation <= VARIATION_RST;
            r_min_count <= MIN_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_VARIATION: r_variation <= i_cfg_data[VAR_W-1:0];
                CFG_MIN_COUNT: r_min_count <= i_cfg_data[MINC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_mean         = r_mean;
    assign o_valid_res    = r_valid_res;
    assign o_cluster_size = r_cluster_size;
    assign o_overflow     = r_overflow;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SAMPLES))
        else $error("sample count beyond capacity");

    a_j_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SRCH_J || r_state == ST_SRCH_JW || r_state == ST_EVAL)
        |-> (r_j > r_i && r_j <= r_count && r_i <= w_half))
        else $error("run pointers out of order");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_best != '0))
        else $error("divide by empty run");

    a_result_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && n_state == ST_IDLE)
        |=> (r_out_valid && r_count == '0 && !r_dropped))
        else $error("burst state not cleared with result");

endmodule

/* sv/dwm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwm_ram
// generic one-write one-read memory with registered read data
// ----------------------------------------------------------------------------
module dwm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
